@@ hw/rtl/dstm_pkg.sv @@
// Shared package for the dual-stream timestamp matcher.
// Field widths, request and status codes, controller/datapath command types.
// No dependencies.
`timescale 1ns / 1ps

package dstm_pkg;

    localparam int TIME_W      = 40;
    localparam int SEQ_W       = 32;
    localparam int TOL_W       = 20;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int QUEUE_DEPTH = 128;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(5000);

    typedef enum logic [REQ_W-1:0] {
        REQ_PRIMARY   = 2'd0,
        REQ_SECONDARY = 2'd1,
        REQ_POLL      = 2'd2
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED     = 3'd0,
        ST_DROPPED    = 3'd1,
        ST_NO_TICK    = 3'd2,
        ST_PRIM_EMPTY = 3'd3,
        ST_MATCHED    = 3'd4,
        ST_NO_MATCH   = 3'd5
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    req_load;
        logic    push_prim;
        logic    push_sec;
        logic    set_pending;
        logic    clr_pending;
        logic    pop_prim;
        logic    pop_sec;
        logic    cap_prim;
        logic    cmp_sec;
        logic    take_match;
        logic    load_out;
        logic    status_en;
        t_status status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             trigger;
        logic             pending;
        logic             prim_full;
        logic             prim_empty;
        logic             sec_full;
        logic             sec_empty;
        logic             match;
        logic             newer;
        logic             out_free;
    } t_dp_stat;

endpackage

@@ hw/rtl/dstm_req_if.sv @@
// Request channel: valid/ready plus one request word.
// Depends on dstm_pkg for field widths.
`timescale 1ns / 1ps

interface dstm_req_if;
    logic                        valid;
    logic                        ready;
    logic [dstm_pkg::REQ_W-1:0]  req_type;
    logic [dstm_pkg::TIME_W-1:0] timestamp;
    logic [dstm_pkg::SEQ_W-1:0]  seq_num;
    logic                        trigger;

    modport source (output valid, req_type, timestamp, seq_num, trigger, input ready);
    modport sink   (input valid, req_type, timestamp, seq_num, trigger, output ready);
endinterface

@@ hw/rtl/dstm_rsp_if.sv @@
// Response channel: valid/ready plus one result word.
// Depends on dstm_pkg for field widths.
`timescale 1ns / 1ps

interface dstm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dstm_pkg::STATUS_W-1:0] status;
    logic [dstm_pkg::TIME_W-1:0]   primary_time;
    logic [dstm_pkg::SEQ_W-1:0]    primary_seq;
    logic [dstm_pkg::TIME_W-1:0]   secondary_time;
    logic [dstm_pkg::SEQ_W-1:0]    secondary_seq;
    logic [dstm_pkg::TIME_W-1:0]   time_gap;

    modport source (output valid, status, primary_time, primary_seq, secondary_time,
                    secondary_seq, time_gap, input ready);
    modport sink   (input valid, status, primary_time, primary_seq, secondary_time,
                    secondary_seq, time_gap, output ready);
endinterface

@@ hw/rtl/dstm_fifo.sv @@
// Circular descriptor FIFO: one-port-write, one-port-read memory, registered read.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module dstm_fifo #(
    parameter int DEPTH  = 128,
    parameter int DATA_W = 72
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_rdata,
    output logic              o_full,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_tail;
    logic [CW-1:0]     r_count;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
        return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_wdata;
        end
        if (i_pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= wrap_inc(r_tail);
            end
            if (i_pop) begin
                r_head <= wrap_inc(r_head);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fifo count above depth");
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full fifo");
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty fifo");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not drop count");
`endif

endmodule

@@ hw/rtl/dstm_datapath.sv @@
// Datapath: request latch, both FIFOs, sync flag, tolerance, gap compare, output register.
// Depends on dstm_pkg and dstm_fifo.
`timescale 1ns / 1ps

module dstm_datapath #(
    parameter int QUEUE_DEPTH = dstm_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dstm_pkg::t_cmd                i_cmd,
    output dstm_pkg::t_dp_stat            o_stat,
    input  logic [dstm_pkg::REQ_W-1:0]    i_req_type,
    input  logic [dstm_pkg::TIME_W-1:0]   i_timestamp,
    input  logic [dstm_pkg::SEQ_W-1:0]    i_seq_num,
    input  logic                          i_trigger,
    input  logic                          i_cfg_we,
    input  logic [dstm_pkg::TOL_W-1:0]    i_cfg_wdata,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [dstm_pkg::STATUS_W-1:0] o_status,
    output logic [dstm_pkg::TIME_W-1:0]   o_primary_time,
    output logic [dstm_pkg::SEQ_W-1:0]    o_primary_seq,
    output logic [dstm_pkg::TIME_W-1:0]   o_secondary_time,
    output logic [dstm_pkg::SEQ_W-1:0]    o_secondary_seq,
    output logic [dstm_pkg::TIME_W-1:0]   o_time_gap
);

    localparam int TW = dstm_pkg::TIME_W;
    localparam int SW = dstm_pkg::SEQ_W;
    localparam int DW = TW + SW;

    // request latch
    logic [dstm_pkg::REQ_W-1:0] r_req_type;
    logic [TW-1:0]              r_req_ts;
    logic [SW-1:0]              r_req_seq;
    logic                       r_req_trig;

    logic                       r_pending;
    logic [dstm_pkg::TOL_W-1:0] r_tol;

    // result under construction
    logic [dstm_pkg::STATUS_W-1:0] r_res_status;
    logic [TW-1:0]                 r_res_pt;
    logic [SW-1:0]                 r_res_ps;
    logic [TW-1:0]                 r_res_st;
    logic [SW-1:0]                 r_res_ss;
    logic [TW-1:0]                 r_res_gap;
    logic [TW-1:0]                 r_cmp_ts;
    logic [SW-1:0]                 r_cmp_seq;
    logic                          r_newer;

    // output register
    logic                          r_out_valid;
    logic [dstm_pkg::STATUS_W-1:0] r_out_status;
    logic [TW-1:0]                 r_out_pt;
    logic [SW-1:0]                 r_out_ps;
    logic [TW-1:0]                 r_out_st;
    logic [SW-1:0]                 r_out_ss;
    logic [TW-1:0]                 r_out_gap;

    logic [DW-1:0] prim_rdata;
    logic [DW-1:0] sec_rdata;
    logic          prim_full, prim_empty, sec_full, sec_empty;
    logic [TW-1:0] sec_ts;
    logic [TW-1:0] gap;
    logic          sec_ge;

    dstm_fifo #(.DEPTH(QUEUE_DEPTH), .DATA_W(DW)) u_prim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_cmd.push_prim),
        .i_wdata ({r_req_ts, r_req_seq}),
        .i_pop   (i_cmd.pop_prim),
        .o_rdata (prim_rdata),
        .o_full  (prim_full),
        .o_empty (prim_empty)
    );

    dstm_fifo #(.DEPTH(QUEUE_DEPTH), .DATA_W(DW)) u_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_cmd.push_sec),
        .i_wdata ({r_req_ts, r_req_seq}),
        .i_pop   (i_cmd.pop_sec),
        .o_rdata (sec_rdata),
        .o_full  (sec_full),
        .o_empty (sec_empty)
    );

    // both differences side by side, pick the non-negative one
    assign sec_ts = sec_rdata[DW-1:SW];
    assign sec_ge = (sec_ts >= r_res_pt);
    assign gap    = sec_ge ? (sec_ts - r_res_pt) : (r_res_pt - sec_ts);

    always_comb begin
        o_stat            = '0;
        o_stat.req_type   = r_req_type;
        o_stat.trigger    = r_req_trig;
        o_stat.pending    = r_pending;
        o_stat.prim_full  = prim_full;
        o_stat.prim_empty = prim_empty;
        o_stat.sec_full   = sec_full;
        o_stat.sec_empty  = sec_empty;
        o_stat.match      = (r_res_gap <= TW'(r_tol));
        o_stat.newer      = r_newer;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req_type   <= i_req_type;
            r_req_ts     <= i_timestamp;
            r_req_seq    <= i_seq_num;
            r_req_trig   <= i_trigger;
            r_res_pt     <= '0;
            r_res_ps     <= '0;
            r_res_st     <= '0;
            r_res_ss     <= '0;
            r_res_gap    <= '0;
        end
        if (i_cmd.status_en) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.cap_prim) begin
            r_res_pt <= prim_rdata[DW-1:SW];
            r_res_ps <= prim_rdata[SW-1:0];
        end
        if (i_cmd.cmp_sec) begin
            r_res_gap <= gap;
            r_newer   <= sec_ge && (sec_ts != r_res_pt);
            r_cmp_ts  <= sec_ts;
            r_cmp_seq <= sec_rdata[SW-1:0];
        end
        if (i_cmd.take_match) begin
            r_res_st <= r_cmp_ts;
            r_res_ss <= r_cmp_seq;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_pt     <= r_res_pt;
            r_out_ps     <= r_res_ps;
            r_out_st     <= r_res_st;
            r_out_ss     <= r_res_ss;
            r_out_gap    <= r_res_gap;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_tol       <= dstm_pkg::TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (i_cmd.set_pending) begin
                r_pending <= 1'b1;
            end else if (i_cmd.clr_pending) begin
                r_pending <= 1'b0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_primary_time   = r_out_pt;
    assign o_primary_seq    = r_out_ps;
    assign o_secondary_time = r_out_st;
    assign o_secondary_seq  = r_out_ss;
    assign o_time_gap       = r_out_gap;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded word not presented");
    a_match_has_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_match |-> (r_res_gap <= TW'(r_tol)))
        else $error("match taken outside tolerance");
`endif

endmodule

@@ hw/rtl/dstm_ctrl.sv @@
// Controller state machine: sequences pushes, polls and the secondary walk.
// Depends on dstm_pkg; talks to the datapath only through t_cmd / t_dp_stat.
`timescale 1ns / 1ps

module dstm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dstm_pkg::t_dp_stat i_stat,
    output dstm_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PRIM_WAIT,
        S_SEC_CMP,
        S_SEC_EVAL,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.status_en = 1'b1;
                n_state         = S_DONE;
                unique case (i_stat.req_type)
                    dstm_pkg::REQ_PRIMARY: begin
                        o_cmd.set_pending = i_stat.trigger;
                        o_cmd.push_prim   = !i_stat.prim_full;
                        o_cmd.status      = i_stat.prim_full ? dstm_pkg::ST_DROPPED
                                                             : dstm_pkg::ST_QUEUED;
                    end
                    dstm_pkg::REQ_SECONDARY: begin
                        o_cmd.push_sec = !i_stat.sec_full;
                        o_cmd.status   = i_stat.sec_full ? dstm_pkg::ST_DROPPED
                                                         : dstm_pkg::ST_QUEUED;
                    end
                    dstm_pkg::REQ_POLL: begin
                        if (!i_stat.pending) begin
                            o_cmd.status = dstm_pkg::ST_NO_TICK;
                        end else if (i_stat.prim_empty) begin
                            o_cmd.clr_pending = 1'b1;
                            o_cmd.status      = dstm_pkg::ST_PRIM_EMPTY;
                        end else begin
                            o_cmd.clr_pending = 1'b1;
                            o_cmd.pop_prim    = 1'b1;
                            o_cmd.status      = dstm_pkg::ST_NO_MATCH;
                            n_state           = S_PRIM_WAIT;
                        end
                    end
                    default: begin
                        o_cmd.status = dstm_pkg::ST_NO_TICK;
                    end
                endcase
            end
            S_PRIM_WAIT: begin
                o_cmd.cap_prim = 1'b1;
                if (i_stat.sec_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.pop_sec = 1'b1;
                    n_state       = S_SEC_CMP;
                end
            end
            S_SEC_CMP: begin
                o_cmd.cmp_sec = 1'b1;
                n_state       = S_SEC_EVAL;
            end
            S_SEC_EVAL: begin
                if (i_stat.match) begin
                    o_cmd.take_match = 1'b1;
                    o_cmd.status_en  = 1'b1;
                    o_cmd.status     = dstm_pkg::ST_MATCHED;
                    n_state          = S_DONE;
                end else if (i_stat.newer || i_stat.sec_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.pop_sec = 1'b1;
                    n_state       = S_SEC_CMP;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (r_state == S_IDLE))
        else $error("ready out of step with state");
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_EXEC))
        else $error("accepted word not executed");
    a_walk_single_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.pop_sec && o_cmd.push_sec) && !(o_cmd.pop_prim && o_cmd.push_prim))
        else $error("push and pop together");
`endif

endmodule

@@ hw/rtl/dual_stream_timestamp_matcher_core.sv @@
// Top level of the dual-stream timestamp matcher.
// Depends on dstm_pkg, dstm_req_if, dstm_rsp_if, dstm_ctrl, dstm_datapath, dstm_fifo.
`timescale 1ns / 1ps

// Pairs primary and secondary camera frames by capture time. Each request word
// is one of: primary frame, secondary frame, or poll. Frames go into their own
// QUEUE_DEPTH-deep FIFO (timestamp + sequence number); a push into a full FIFO
// is dropped and reported. A primary frame with trigger set raises a sticky
// sync flag (also when the frame itself is dropped; several triggers merge).
// A poll with the flag set clears it, pops the oldest primary frame, and then
// pops secondary frames until one is within sync_tolerance (matched), one is
// newer than primary+tolerance (no match; that frame is consumed), or the
// secondary FIFO runs dry. Every request word yields exactly one result word.
// Throughput: one word at a time. A frame push, or a poll that pops nothing,
// passes through the execute and done states before its result is loaded; a
// poll that pops a primary waits for the FIFO's registered read, then walks
// the secondary frames, each popped, gap-compared into a datapath register and
// evaluated by the controller. Ready returns in the cycle after the load. The
// result sits in an output register, so the next request is taken while it
// waits; the datapath stalls only if a second result is ready before the first
// one is taken. The tolerance register (i_cfg_we / i_cfg_wdata, reset 5000 us)
// is to be written by the user only while the block is idle; the block does not
// enforce this. FIFO memories need no clearing after reset.
module dual_stream_timestamp_matcher_core #(
    parameter int QUEUE_DEPTH = dstm_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    dstm_req_if.sink                   i_req,
    dstm_rsp_if.source                 o_rsp,
    input  logic                       i_cfg_we,
    input  logic [dstm_pkg::TOL_W-1:0] i_cfg_wdata
);

    // command / status bundle between controller and datapath
    dstm_pkg::t_cmd     cmd;
    dstm_pkg::t_dp_stat stat;
    logic               in_ready;

    dstm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dstm_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (i_req.req_type),
        .i_timestamp      (i_req.timestamp),
        .i_seq_num        (i_req.seq_num),
        .i_trigger        (i_req.trigger),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_primary_time   (o_rsp.primary_time),
        .o_primary_seq    (o_rsp.primary_seq),
        .o_secondary_time (o_rsp.secondary_time),
        .o_secondary_seq  (o_rsp.secondary_seq),
        .o_time_gap       (o_rsp.time_gap)
    );

    // ready is registered in the controller: high exactly in its idle state
    assign i_req.ready = in_ready;

endmodule
